[hw/rtl/cpu_hotplug_need_estimator_assert.svh]
// Assertion macros shared by the estimator RTL.
`ifndef CPU_HOTPLUG_NEED_ESTIMATOR_ASSERT_SVH
`define CPU_HOTPLUG_NEED_ESTIMATOR_ASSERT_SVH

// Checked on the rising clock edge, muted while reset is asserted.
`define CHNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CHNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/chne_pkg.sv]
// Package with widths, constants and types of the hot-plug need estimator.
`timescale 1ns / 1ps
package chne_pkg;

  localparam int unsigned DEPTH   = 25;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned LOAD_W  = 7;
  localparam int unsigned FREQ_W  = 12;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned TASKS_W = 10;
  localparam int unsigned CORES_W = 4;
  localparam int unsigned LF_W    = 21;
  localparam int unsigned T_W     = 9;
  localparam int unsigned TASK_W  = 17;
  localparam int unsigned PROD_W  = LF_W + T_W;
  localparam int unsigned WSUM_W  = 35;
  localparam int unsigned TSUM_W  = 14;
  localparam int unsigned SSUM_W  = 19;
  localparam int unsigned THR_W   = 20;
  localparam int unsigned IN_W    = 72;
  localparam int unsigned OUT_W   = 8;

  localparam logic [T_W-1:0]    TIME_CLAMP = 9'd500;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 12'd1200;
  localparam logic [TASK_W-1:0] TASK_SCALE = 17'd100;

  // Window lengths in ms.
  localparam logic [TSUM_W-1:0] WIN_100 = 14'd100;
  localparam logic [TSUM_W-1:0] WIN_150 = 14'd150;
  localparam logic [TSUM_W-1:0] WIN_250 = 14'd250;
  localparam logic [TSUM_W-1:0] WIN_300 = 14'd300;

  // Load threshold factors, multiplied by the maximum frequency.
  localparam logic [7:0] KLO_TWO   = 8'd20;
  localparam logic [7:0] KLO_THREE = 8'd60;
  localparam logic [7:0] KLO_FOUR  = 8'd90;
  localparam logic [7:0] KHI_ONE   = 8'd80;
  localparam logic [7:0] KHI_TWO   = 8'd120;
  localparam logic [7:0] KHI_THREE = 8'd180;

  // Task thresholds on sums: avg(n) >= C is sum >= C*n, avg(n) <= C is sum <= C*n+n-1.
  localparam logic [SSUM_W-1:0] TS_ONE_UP    = 19'd450;
  localparam logic [SSUM_W-1:0] TS_TWO_DOWN  = 19'd200;
  localparam logic [SSUM_W-1:0] TS_TWO_UP    = 19'd1000;
  localparam logic [SSUM_W-1:0] TS_THREE_DN  = 19'd601;
  localparam logic [SSUM_W-1:0] TS_THREE_UP  = 19'd1400;
  localparam logic [SSUM_W-1:0] TS_FOUR_DOWN = 19'd1202;

  localparam logic [LOAD_W-1:0] L0_UP_MIN   = 7'd80;
  localparam logic [LOAD_W-1:0] L0_DOWN_LIM = 7'd100;

  localparam logic [CORES_W-1:0] CORES_ONE   = 4'd1;
  localparam logic [CORES_W-1:0] CORES_TWO   = 4'd2;
  localparam logic [CORES_W-1:0] CORES_THREE = 4'd3;
  localparam logic [CORES_W-1:0] CORES_FOUR  = 4'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [WSUM_W-1:0] w100;
    logic [WSUM_W-1:0] w150;
    logic [WSUM_W-1:0] w250;
    logic [WSUM_W-1:0] w300;
    logic [TSUM_W-1:0] t100;
    logic [TSUM_W-1:0] t150;
    logic [TSUM_W-1:0] t250;
    logic [TSUM_W-1:0] t300;
    logic [SSUM_W-1:0] s1;
    logic [SSUM_W-1:0] s2;
    logic [SSUM_W-1:0] s3;
    logic [SSUM_W-1:0] s4;
  } walk_res_t;

endpackage

[hw/rtl/cpu_hotplug_need_estimator.sv]
// Top level of the core hot-plug need estimator.
`timescale 1ns / 1ps
// Usage. Each beat on the slave stream is one load sample; each beat on the
// master stream is the decision for that sample: the number of cores that
// should be online and a wake request. One result beat per input beat, in order.
// The configuration port writes the maximum core frequency whenever cfg_we_i
// is high; write it only while no sample is in flight.
// Timing. A sample is taken when s_axis_tvalid and s_axis_tready are high.
// Its history entries are written to the two ring memories at that edge. The
// walker then reads all 25 ring entries, one read per cycle from the memory
// port, through a read, a multiply and an accumulate stage, and the decision
// unit registers the scaled thresholds and then the products before the result
// is ready. One sample is processed at a time: a new sample is taken only
// after the decision for the last one has been loaded into the output register.
// Stalls. The result sits in an output register; the next sample is taken
// while it waits. If the receiver still holds off when the next decision is
// ready, the block waits and takes no new sample.
// Reset. Both rings read as zero (a valid bit per entry is cleared), the head
// returns to zero and the maximum frequency returns to 1200 MHz. No clearing
// pass is needed; the block is ready in the first cycle after reset.
module cpu_hotplug_need_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [chne_pkg::FREQ_W-1:0]  cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // load_core0, load_core1, load_core2, load_core3, freq_mhz, elapsed_ms,
  // running_tasks, online_cores, then two zero bits
  input  logic [chne_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // needed_cores, wake_request, then three zero bits
  output logic [chne_pkg::OUT_W-1:0]   m_axis_tdata
);
  import chne_pkg::*;

  `include "cpu_hotplug_need_estimator_assert.svh"

  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  state_e state_q, state_d;

  logic [FREQ_W-1:0]  max_freq_q;
  logic [IDX_W-1:0]   head_q, head_nxt;
  logic [DEPTH-1:0]   valid_q;
  logic [CORES_W-1:0] online_q;
  logic [LOAD_W-1:0]  l0_q;
  logic               walk_start_q;
  logic               accept;

  logic [LOAD_W-1:0]  ld0, ld1, ld2, ld3;
  logic [FREQ_W-1:0]  freq;
  logic [MS_W-1:0]    ms;
  logic [TASKS_W-1:0] tasks;
  logic [8:0]         load_sum;
  logic [LF_W-1:0]    wr_lf;
  logic [T_W-1:0]     wr_t;
  logic [TASK_W-1:0]  wr_task;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [LF_W+T_W-1:0] rd_load;
  logic [TASK_W-1:0]  rd_task;
  logic               walk_done;
  walk_res_t          walk_res;

  logic               dec_start, dec_done, dec_wake;
  logic [CORES_W-1:0] dec_need;
  logic               out_load;
  logic               out_valid_q;
  logic [CORES_W-1:0] out_need_q;
  logic               out_wake_q;

  assign ld0   = s_axis_tdata[6:0];
  assign ld1   = s_axis_tdata[13:7];
  assign ld2   = s_axis_tdata[20:14];
  assign ld3   = s_axis_tdata[27:21];
  assign freq  = s_axis_tdata[39:28];
  assign ms    = s_axis_tdata[55:40];
  assign tasks = s_axis_tdata[65:56];

  assign load_sum = 9'(ld0) + 9'(ld1) + 9'(ld2) + 9'(ld3);
  assign wr_lf    = LF_W'(load_sum * freq);
  assign wr_t     = (ms > MS_W'(TIME_CLAMP)) ? TIME_CLAMP : ms[T_W-1:0];
  assign wr_task  = TASK_W'(tasks * TASK_SCALE);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign head_nxt      = (head_q == LAST) ? '0 : head_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_freq_q <= FREQ_RESET;
    end else if (cfg_we_i) begin
      max_freq_q <= cfg_wdata_i;
    end
  end

  // The ring head advances first; the new entry lands at the new head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      valid_q      <= '0;
      walk_start_q <= 1'b0;
    end else begin
      walk_start_q <= accept;
      if (accept) begin
        head_q            <= head_nxt;
        valid_q[head_nxt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      online_q <= s_axis_tdata[69:66];
      l0_q     <= ld0;
    end
  end

  chne_ram #(
    .WIDTH(LF_W + T_W),
    .DEPTH(DEPTH)
  ) u_load_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(head_nxt),
    .wdata_i({wr_lf, wr_t}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_load)
  );

  chne_ram #(
    .WIDTH(TASK_W),
    .DEPTH(DEPTH)
  ) u_task_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(head_nxt),
    .wdata_i(wr_task),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_task)
  );

  chne_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (walk_start_q),
    .head_i   (head_q),
    .valid_i  (valid_q),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .lf_i     (rd_load[LF_W+T_W-1:T_W]),
    .t_i      (rd_load[T_W-1:0]),
    .task_i   (rd_task),
    .done_o   (walk_done),
    .res_o    (walk_res)
  );

  assign dec_start = walk_done;

  chne_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dec_start),
    .res_i     (walk_res),
    .online_i  (online_q),
    .l0_i      (l0_q),
    .max_freq_i(max_freq_q),
    .done_o    (dec_done),
    .need_o    (dec_need),
    .wake_o    (dec_wake)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The decision stays on the decide outputs until the next sample is taken, so a
  // stalled output only has to wait here.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) state_d = ST_DECIDE;
      end
      ST_DECIDE, ST_HOLD: begin
        if ((state_q == ST_HOLD) || dec_done) begin
          if (!out_valid_q || m_axis_tready) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d  = ST_HOLD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_need_q <= dec_need;
      out_wake_q <= dec_wake;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_wake_q, out_need_q};

  `CHNE_ASSERT(a_walk_done_in_walk, walk_done |-> (state_q == ST_WALK), "walk ended outside walk state")
  `CHNE_ASSERT(a_dec_done_in_decide, dec_done |-> (state_q == ST_DECIDE), "decision outside decide state")
  `CHNE_ASSERT(a_accept_starts_walk, accept |=> (walk_start_q && state_q == ST_WALK), "sample did not start a walk")
  `CHNE_ASSERT_ALWAYS(a_no_read_when_idle, !(rd_en && (state_q == ST_IDLE)), "ring read while idle")

endmodule

[hw/rtl/chne_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module chne_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/chne_walk.sv]
// Ring walker: reads history newest first and accumulates window sums.
`timescale 1ns / 1ps
module chne_walk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [chne_pkg::IDX_W-1:0]  head_i,
  input  logic [chne_pkg::DEPTH-1:0]  valid_i,
  output logic                        rd_en_o,
  output logic [chne_pkg::IDX_W-1:0]  rd_addr_o,
  input  logic [chne_pkg::LF_W-1:0]   lf_i,
  input  logic [chne_pkg::T_W-1:0]    t_i,
  input  logic [chne_pkg::TASK_W-1:0] task_i,
  output logic                        done_o,
  output chne_pkg::walk_res_t         res_o
);
  import chne_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  logic              issue_q;
  logic [IDX_W-1:0]  k_q, idx_q;
  logic              v1_q, ev1_q, v2_q, done_q;
  logic [IDX_W-1:0]  k1_q, k2_q;
  logic [PROD_W-1:0] prod_q;
  logic [T_W-1:0]    t2_q;
  logic [TASK_W-1:0] task2_q;
  logic [TSUM_W-1:0] tsum_q, tsum_d;
  logic [WSUM_W-1:0] wsum_q, wsum_d;
  logic [SSUM_W-1:0] ssum_q, ssum_d;
  walk_res_t         res_q;

  assign rd_en_o   = issue_q;
  assign rd_addr_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      k_q     <= '0;
      idx_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1_q   <= issue_q;
      v2_q   <= v1_q;
      done_q <= v2_q && (k2_q == LAST);
      if (start_i) begin
        issue_q <= 1'b1;
        k_q     <= '0;
        idx_q   <= head_i;
      end else if (issue_q) begin
        issue_q <= (k_q != LAST);
        k_q     <= k_q + 1'b1;
        idx_q   <= (idx_q == '0) ? LAST : idx_q - 1'b1;
      end
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i) begin
    k1_q    <= k_q;
    ev1_q   <= valid_i[idx_q];
    k2_q    <= k1_q;
    prod_q  <= ev1_q ? PROD_W'(lf_i * t_i) : '0;
    t2_q    <= ev1_q ? t_i : '0;
    task2_q <= ev1_q ? task_i : '0;
  end

  assign tsum_d = tsum_q + TSUM_W'(t2_q);
  assign wsum_d = wsum_q + WSUM_W'(prod_q);
  assign ssum_d = ssum_q + SSUM_W'(task2_q);

  // An entry belongs to a window while the time before it is still short of the window.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      tsum_q <= '0;
      wsum_q <= '0;
      ssum_q <= '0;
      res_q  <= '0;
    end else if (v2_q) begin
      tsum_q <= tsum_d;
      wsum_q <= wsum_d;
      ssum_q <= ssum_d;
      if (tsum_q < WIN_100) begin
        res_q.w100 <= wsum_d;
        res_q.t100 <= tsum_d;
      end
      if (tsum_q < WIN_150) begin
        res_q.w150 <= wsum_d;
        res_q.t150 <= tsum_d;
      end
      if (tsum_q < WIN_250) begin
        res_q.w250 <= wsum_d;
        res_q.t250 <= tsum_d;
      end
      if (tsum_q < WIN_300) begin
        res_q.w300 <= wsum_d;
        res_q.t300 <= tsum_d;
      end
      case (k2_q)
        IDX_W'(0): res_q.s1 <= ssum_d;
        IDX_W'(1): res_q.s2 <= ssum_d;
        IDX_W'(2): res_q.s3 <= ssum_d;
        IDX_W'(3): res_q.s4 <= ssum_d;
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/chne_decide.sv]
// Threshold evaluation: scales limits by the maximum frequency and picks the core count.
`timescale 1ns / 1ps
module chne_decide (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  chne_pkg::walk_res_t          res_i,
  input  logic [chne_pkg::CORES_W-1:0] online_i,
  input  logic [chne_pkg::LOAD_W-1:0]  l0_i,
  input  logic [chne_pkg::FREQ_W-1:0]  max_freq_i,
  output logic                         done_o,
  output logic [chne_pkg::CORES_W-1:0] need_o,
  output logic                         wake_o
);
  import chne_pkg::*;

  logic              v1_q, v2_q;
  logic [7:0]        klo, khi;
  logic [THR_W-1:0]  klo_q, khi_q;
  logic [WSUM_W-1:0] plo_q, phi_q, whi_q, whi;
  logic [TSUM_W-1:0] thi_q, thi;
  logic              lo_ok, hi_ok;
  logic [CORES_W-1:0] need;

  always_comb begin
    klo = '0;
    khi = '0;
    whi = res_i.w100;
    thi = res_i.t100;
    unique case (online_i)
      CORES_ONE: begin
        khi = KHI_ONE;
      end
      CORES_TWO: begin
        klo = KLO_TWO;
        khi = KHI_TWO;
        whi = res_i.w150;
        thi = res_i.t150;
      end
      CORES_THREE: begin
        klo = KLO_THREE;
        khi = KHI_THREE;
        whi = res_i.w250;
        thi = res_i.t250;
      end
      CORES_FOUR: begin
        klo = KLO_FOUR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  // avg > K*F holds when wsum >= (K*F+1)*tsum; avg < K*F when wsum < K*F*tsum.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      klo_q <= THR_W'(max_freq_i * klo);
      khi_q <= THR_W'(max_freq_i * khi) + 1'b1;
      whi_q <= whi;
      thi_q <= thi;
    end
    if (v1_q) begin
      plo_q <= WSUM_W'(klo_q) * WSUM_W'(res_i.t300);
      phi_q <= WSUM_W'(khi_q) * WSUM_W'(thi_q);
    end
  end

  assign lo_ok = (res_i.t300 == '0) ? (klo_q != '0) : (res_i.w300 < plo_q);
  assign hi_ok = (thi_q != '0) && (whi_q >= phi_q);

  always_comb begin
    need = online_i;
    unique case (online_i)
      CORES_ONE: begin
        if (l0_i >= L0_UP_MIN && hi_ok && res_i.s3 >= TS_ONE_UP) need = online_i + 1'b1;
      end
      CORES_TWO: begin
        if (res_i.s1 <= TS_TWO_DOWN && l0_i < L0_DOWN_LIM && lo_ok) begin
          need = online_i - 1'b1;
        end else if (hi_ok && res_i.s4 >= TS_TWO_UP) begin
          need = online_i + 1'b1;
        end
      end
      CORES_THREE: begin
        if (res_i.s2 <= TS_THREE_DN && lo_ok) begin
          need = online_i - 1'b1;
        end else if (hi_ok && res_i.s4 >= TS_THREE_UP) begin
          need = online_i + 1'b1;
        end
      end
      CORES_FOUR: begin
        if (res_i.s3 <= TS_FOUR_DOWN && lo_ok) need = online_i - 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = v2_q;
  assign need_o = need;
  assign wake_o = (online_i >= CORES_TWO) && (need >= CORES_TWO);

endmodule
